/* rtl/lcsf_pkg.sv */
package lcsf_pkg;

	localparam int VALUE_W    = 24;
	localparam int WEIGHT_W   = 16;
	localparam int SCALE_W    = 35;
	localparam int PCT_W      = 7;
	localparam int LOW_ONES_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam int SCALE_MUL = 1000;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_REJECT = 2'd1,
		ST_SCALE  = 2'd2,
		ST_ZERO   = 2'd3
	} status_t;

	localparam int STATUS_W = $bits(status_t);

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_SCALE  = 1'b1
	} opcode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_PERCENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARE_COUNTS    = 1'd1;

endpackage

/* rtl/lcsf_if.sv */
interface lcsf_cmd_if #(parameter int SAMPLE_BITS = 24);
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [SAMPLE_BITS-1:0]            raw_sample;
	logic [lcsf_pkg::WEIGHT_W-1:0]     known_weight;

	modport source (output valid, opcode, raw_sample, known_weight, input ready);
	modport sink (input valid, opcode, raw_sample, known_weight, output ready);
endinterface

interface lcsf_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [lcsf_pkg::STATUS_W-1:0]        status;
	logic signed [lcsf_pkg::VALUE_W-1:0]  sample_value;
	logic signed [lcsf_pkg::VALUE_W-1:0]  filtered_value;
	logic signed [lcsf_pkg::SCALE_W-1:0]  scale_factor;

	modport source (output valid, status, sample_value, filtered_value, scale_factor,
		input ready);
	modport sink (input valid, status, sample_value, filtered_value, scale_factor,
		output ready);
endinterface

interface lcsf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lcsf_pkg::CFG_IDX_W-1:0]    index;
	logic [lcsf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lcsf_front.sv */
module lcsf_front #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	lcsf_cmd_if.sink cmd,
	output logic push_valid,
	input  logic push_ready,
	output logic [lcsf_pkg::STATUS_W+SAMPLE_BITS+lcsf_pkg::WEIGHT_W-1:0] push_data
);
	import lcsf_pkg::*;

	logic                   valid_s1;
	status_t                kind_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [WEIGHT_W-1:0]    weight_s1;
	logic                   bogus;
	logic                   take;

	// all ones, or low half-word all ones
	assign bogus = (&cmd.raw_sample) || (&cmd.raw_sample[LOW_ONES_W-1:0]);
	assign cmd.ready = !valid_s1 || push_ready;
	assign take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= cmd.raw_sample;
			weight_s1 <= cmd.known_weight;
			if (cmd.opcode == OP_SAMPLE) begin
				kind_s1 <= bogus ? ST_REJECT : ST_ACCEPT;
			end else begin
				kind_s1 <= (cmd.known_weight == '0) ? ST_ZERO : ST_SCALE;
			end
		end
	end

	assign push_valid = valid_s1;
	assign push_data = {kind_s1, sample_s1, weight_s1};

endmodule

/* rtl/lcsf_queue.sv */
module lcsf_queue #(
	parameter int WIDTH = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int DEPTH = 2;
	localparam int PTR_W = 1;
	localparam int CNT_W = 2;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/lcsf_div.sv */
module lcsf_div #(
	parameter int DW = 35
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [DW-1:0]          dividend,
	input  logic [lcsf_pkg::WEIGHT_W-1:0] divisor,
	output logic                          done,
	output logic signed [DW-1:0]          quotient
);
	import lcsf_pkg::*;

	localparam int CNT_W = $clog2(DW);
	localparam int REM_W = WEIGHT_W + 1;

	logic                busy_q;
	logic                fin_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic [DW-1:0]       work_q;
	logic [WEIGHT_W-1:0] rem_q;
	logic [WEIGHT_W-1:0] divisor_q;
	logic signed [DW-1:0] quotient_q;
	logic [DW-1:0]       mag;
	logic [REM_W-1:0]    rem_sh;
	logic [REM_W-1:0]    rem_sub;
	logic                fits;

	assign mag = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
	assign rem_sh = {rem_q, work_q[DW-1]};
	assign fits = rem_sh >= {1'b0, divisor_q};
	assign rem_sub = rem_sh - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle on magnitudes, sign applied at the end
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			work_q <= mag;
			rem_q <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DW-2:0], fits};
			rem_q <= fits ? rem_sub[WEIGHT_W-1:0] : rem_sh[WEIGHT_W-1:0];
		end
		if (fin_q) begin
			quotient_q <= neg_q ? $signed(~work_q + DW'(1)) : $signed(work_q);
		end
	end

	assign done = done_q;
	assign quotient = quotient_q;

endmodule

/* rtl/lcsf_back.sv */
module lcsf_back #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  logic [lcsf_pkg::STATUS_W+SAMPLE_BITS+lcsf_pkg::WEIGHT_W-1:0] pop_data,
	lcsf_cfg_if.sink cfg,
	lcsf_res_if.source res
);
	import lcsf_pkg::*;

	localparam int ENTRY_W = STATUS_W + SAMPLE_BITS + WEIGHT_W;
	localparam int DIFF_W = ((SAMPLE_BITS > VALUE_W) ? SAMPLE_BITS : VALUE_W) + 1;
	localparam int PROD_W = SAMPLE_BITS + 8;
	localparam int DW = (PROD_W > DIFF_W + 10) ? PROD_W : DIFF_W + 10;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MULA  = 6'b000010,
		S_MULB  = 6'b000100,
		S_START = 6'b001000,
		S_WAIT  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                    state_q;
	status_t                   kind_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [WEIGHT_W-1:0]       weight_q;
	logic signed [DW-1:0]      term_q;
	logic signed [DW-1:0]      dividend_q;
	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic [PCT_W-1:0]          pct_q;
	logic signed [VALUE_W-1:0] tare_q;
	logic                      out_valid_q;
	status_t                   status_q;
	logic signed [VALUE_W-1:0] sample_value_q;
	logic signed [VALUE_W-1:0] filtered_q;
	logic signed [SCALE_W-1:0] scale_q;

	status_t                   pop_kind;
	logic [PCT_W-1:0]          pct_sat;
	logic [PCT_W-1:0]          pct_inv;
	logic signed [PROD_W-1:0]  samp_prod;
	logic signed [PROD_W-1:0]  avg_prod;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [SAMPLE_BITS-1:0] avg_new;
	logic [WEIGHT_W-1:0]       div_divisor;
	logic                      div_done;
	logic signed [DW-1:0]      div_quotient;
	logic                      out_free;

	assign pop_kind = status_t'(pop_data[ENTRY_W-1 -: STATUS_W]);
	assign pop_ready = state_q == S_IDLE;
	assign out_free = !out_valid_q || res.ready;

	assign pct_sat = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
	assign pct_inv = PCT_FULL - pct_sat;
	assign samp_prod = sample_q * $signed({1'b0, pct_sat});
	assign avg_prod = avg_q * $signed({1'b0, pct_inv});
	assign diff = DIFF_W'(avg_q) - DIFF_W'(tare_q);
	assign avg_new = SAMPLE_BITS'(div_quotient);
	assign div_divisor = (kind_q == ST_SCALE) ? weight_q : WEIGHT_W'(PCT_FULL);

	lcsf_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (dividend_q),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			avg_q <= '0;
			pct_q <= PCT_FULL;
			tare_q <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_FILTER_PERCENT: pct_q <= cfg.data[PCT_W-1:0];
					CFG_TARE_COUNTS:    tare_q <= $signed(cfg.data);
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						if (pop_kind == ST_ACCEPT || pop_kind == ST_SCALE) begin
							state_q <= S_MULA;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_MULA:  state_q <= S_MULB;
				S_MULB:  state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (kind_q == ST_ACCEPT) begin
							avg_q <= avg_new;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop_valid) begin
			kind_q <= pop_kind;
			sample_q <= $signed(pop_data[WEIGHT_W +: SAMPLE_BITS]);
			weight_q <= pop_data[WEIGHT_W-1:0];
		end
		if (state_q == S_MULA) begin
			term_q <= (kind_q == ST_ACCEPT) ? DW'(samp_prod) : DW'(diff);
		end
		if (state_q == S_MULB) begin
			dividend_q <= (kind_q == ST_ACCEPT) ? term_q + DW'(avg_prod)
				: term_q * DW'(SCALE_MUL);
		end
		if (state_q == S_OUT && out_free) begin
			status_q <= kind_q;
			case (kind_q)
				ST_ACCEPT: begin
					sample_value_q <= VALUE_W'(sample_q);
					filtered_q <= VALUE_W'(avg_new);
					scale_q <= '0;
				end
				ST_SCALE: begin
					sample_value_q <= '0;
					filtered_q <= VALUE_W'(avg_q);
					scale_q <= SCALE_W'(div_quotient);
				end
				default: begin
					sample_value_q <= '0;
					filtered_q <= VALUE_W'(avg_q);
					scale_q <= '0;
				end
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.status = status_q;
	assign res.sample_value = sample_value_q;
	assign res.filtered_value = filtered_q;
	assign res.scale_factor = scale_q;

endmodule

/* rtl/load_cell_sample_filter.sv */
// path: an accepted sample or a scale item goes through the multiply steps and the
// bit-serial divider; a rejected sample or a zero weight goes straight to output
// the back end takes no new item until it is through with the last, and its divider is
// shared by the average update and the scale computation (one quotient bit a cycle)
// reset: asynchronous, clears the queue and handshakes, average to zero,
// filter percent to 100 and tare to zero; no clearing pass
module load_cell_sample_filter #(
	parameter int SAMPLE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	lcsf_cmd_if.sink cmd,
	lcsf_res_if.source res,
	lcsf_cfg_if.sink cfg
);
	import lcsf_pkg::*;

	localparam int ENTRY_W = STATUS_W + SAMPLE_BITS + WEIGHT_W;

	logic               push_valid;
	logic               push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	lcsf_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lcsf_queue #(.WIDTH(ENTRY_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lcsf_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg       (cfg),
		.res       (res)
	);

endmodule
